/* rtl/core/bhsr_pkg.sv */
// Shared types and constants for the byte histogram with sparse readout.
// Holds the word structs, op codes, fetch state encoding and store control.
// No dependencies.
package bhsr_pkg;

  // Op codes of an input word
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Widest symbol and reported count
  localparam int SYMBOL_BITS = 8;
  localparam int OCC_BITS    = 16;
  localparam logic [OCC_BITS-1:0] OCC_MAX = '1;

  typedef struct packed {
    logic                   op;
    logic [SYMBOL_BITS-1:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic [OCC_BITS-1:0]    occurrences;
    logic                   found;
  } result_t;

  // Readout sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_t;

  // Readout side control into the bin store
  typedef struct packed {
    logic                   rd_en;
    logic                   clear;
    logic [SYMBOL_BITS-1:0] addr;
  } store_ctrl_t;

endpackage

/* rtl/core/byte_histogram_sparse_readout_top.sv */
// Top level of the byte histogram with sparse readout: input word decode,
// readout sequencer and result register. Depends on bhsr_pkg, bhsr_store.
//
// Usage:
//   item channel (item_valid / item_stall / item): op OP_COUNT adds
//   byte_value to its bin (bins saturate at all ones; bytes not below
//   SYMBOL_COUNT are ignored); op OP_FETCH asks for the next nonzero bin.
//   result channel (result_valid / result_stall / result): one word per
//   fetch, none per count.
// Throughput and fetch walk:
//   Count words are taken one per cycle while item_stall is low, through
//   a two-stage read-modify-write on the bin memory with forwarding.
//   A fetch holds item_stall high while the sequencer walks the valid bits
//   one bin per cycle from the scan position, pausing while a waiting result
//   is stalled, until it finds a nonzero bin or passes the last one (found=0).
//   The walk tests one valid bit per step; a hit adds one memory read.
// Reset: clears all bin valid bits and the scan position; no sweep needed.
// Readout end (found=0) clears all bins at once and rewinds the scan.
// Receiver stall: a waiting result is held; counting continues until a new
//   fetch is taken, and that fetch waits before loading the result register.
module byte_histogram_sparse_readout_top #(
  parameter int COUNT_BITS   = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bhsr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bhsr_pkg::result_t result
);

  localparam int ADDR_BITS = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int POS_BITS  = $clog2(SYMBOL_COUNT + 1);
  localparam int WIDE_BITS = COUNT_BITS + bhsr_pkg::OCC_BITS;

  bhsr_pkg::state_t      state;
  bhsr_pkg::state_t      state_next;
  logic [POS_BITS-1:0]   scan_pos;
  logic [POS_BITS-1:0]   scan_pos_next;
  bhsr_pkg::store_ctrl_t ctrl;
  bhsr_pkg::result_t     res_next;
  logic                  res_load;
  logic                  out_free;
  logic                  item_take;
  logic                  cnt_en;
  logic                  scan_hit;
  logic [COUNT_BITS-1:0] rd_data;
  logic [WIDE_BITS-1:0]  rd_wide;

  assign item_stall = (state != bhsr_pkg::ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign cnt_en     = item_take && (item.op == bhsr_pkg::OP_COUNT) &&
                      ({1'b0, item.byte_value} < 9'(SYMBOL_COUNT));
  assign out_free   = !result_valid || !result_stall;
  assign rd_wide    = WIDE_BITS'(rd_data);

  bhsr_store #(
    .COUNT_BITS  (COUNT_BITS),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cnt_en  (cnt_en),
    .cnt_addr(item.byte_value),
    .ctrl    (ctrl),
    .scan_hit(scan_hit),
    .rd_data (rd_data)
  );

  // Sequencer state and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bhsr_pkg::ST_IDLE;
      scan_pos <= '0;
    end else begin
      state    <= state_next;
      scan_pos <= scan_pos_next;
    end
  end

  // Walk the bins, read a hit, report it or finish the round
  always_comb begin
    state_next    = state;
    scan_pos_next = scan_pos;
    ctrl.rd_en    = 1'b0;
    ctrl.clear    = 1'b0;
    ctrl.addr     = bhsr_pkg::SYMBOL_BITS'(scan_pos[ADDR_BITS-1:0]);
    res_load      = 1'b0;
    res_next      = '0;
    unique case (state)
      bhsr_pkg::ST_IDLE: begin
        if (item_take && item.op == bhsr_pkg::OP_FETCH) begin
          state_next = bhsr_pkg::ST_SCAN;
        end
      end
      bhsr_pkg::ST_SCAN: begin
        if (out_free) begin
          if (scan_pos == POS_BITS'(SYMBOL_COUNT)) begin
            res_load      = 1'b1;
            ctrl.clear    = 1'b1;
            scan_pos_next = '0;
            state_next    = bhsr_pkg::ST_IDLE;
          end else if (scan_hit) begin
            ctrl.rd_en = 1'b1;
            state_next = bhsr_pkg::ST_READ;
          end else begin
            scan_pos_next = scan_pos + POS_BITS'(1);
          end
        end
      end
      bhsr_pkg::ST_READ: begin
        res_load         = 1'b1;
        res_next.symbol  = bhsr_pkg::SYMBOL_BITS'(scan_pos[ADDR_BITS-1:0]);
        res_next.found   = 1'b1;
        if (rd_wide > WIDE_BITS'(bhsr_pkg::OCC_MAX)) begin
          res_next.occurrences = bhsr_pkg::OCC_MAX;
        end else begin
          res_next.occurrences = rd_wide[bhsr_pkg::OCC_BITS-1:0];
        end
        scan_pos_next = scan_pos + POS_BITS'(1);
        state_next    = bhsr_pkg::ST_IDLE;
      end
      default: begin
        state_next = bhsr_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (res_load) begin
      result <= res_next;
    end
  end

`ifndef SYNTHESIS
  // End of readout reports nothing
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.symbol == '0 && result.occurrences == '0)
    else $error("finished readout carries a bin");

  // A reported bin is never empty
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |-> result.occurrences != '0)
    else $error("empty bin reported");

  // A read hit only loads into a free result register
  assert property (@(posedge clk) disable iff (rst)
    state == bhsr_pkg::ST_READ |-> !result_valid)
    else $error("result overwritten");

  // Finishing a round rewinds the scan
  assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> scan_pos == '0)
    else $error("scan not rewound");
`endif

endmodule

/* rtl/core/bhsr_store.sv */
// Bin store: count memory with registered read, per-bin valid bits and the
// read-modify-write increment pipeline with forwarding.
// Depends on bhsr_pkg.
module bhsr_store #(
  parameter int COUNT_BITS   = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cnt_en,
  input  logic [bhsr_pkg::SYMBOL_BITS-1:0] cnt_addr,
  input  bhsr_pkg::store_ctrl_t     ctrl,
  output logic                      scan_hit,
  output logic [COUNT_BITS-1:0]     rd_data
);

  localparam int ADDR_BITS = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [COUNT_BITS-1:0]   mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid;

  // Increment stage registers
  logic                  s1_valid;
  logic [ADDR_BITS-1:0]  s1_addr;
  logic                  s1_fwd;
  logic [COUNT_BITS-1:0] s1_fwd_val;

  logic [ADDR_BITS-1:0]  in_addr;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  rd_en;
  logic [COUNT_BITS-1:0] base;
  logic [COUNT_BITS-1:0] new_count;

  assign in_addr  = cnt_addr[ADDR_BITS-1:0];
  assign rd_en    = cnt_en | ctrl.rd_en;
  assign rd_addr  = ctrl.rd_en ? ctrl.addr[ADDR_BITS-1:0] : in_addr;
  assign scan_hit = valid[ctrl.addr[ADDR_BITS-1:0]];

  // Pick the current count: forwarded, stored, or empty bin
  always_comb begin
    if (s1_fwd) begin
      base = s1_fwd_val;
    end else if (valid[s1_addr]) begin
      base = rd_data;
    end else begin
      base = '0;
    end
    new_count = (&base) ? base : base + COUNT_BITS'(1);
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[s1_addr] <= new_count;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Increment pipeline; forward when back-to-back words hit the same bin
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cnt_en;
    end
    s1_addr    <= in_addr;
    s1_fwd     <= s1_valid && (s1_addr == in_addr);
    s1_fwd_val <= new_count;
  end

  // Valid bits: set on write, drop all at end of readout
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= '0;
    end else if (s1_valid) begin
      valid[s1_addr] <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // A readout read never collides with a count read
  assert property (@(posedge clk) disable iff (rst) !(cnt_en && ctrl.rd_en))
    else $error("count and readout read in the same cycle");

  // A stored count is never zero
  assert property (@(posedge clk) disable iff (rst) s1_valid |-> new_count != '0)
    else $error("written count is zero");

  // Clearing never races a pending increment
  assert property (@(posedge clk) disable iff (rst) ctrl.clear |-> !s1_valid)
    else $error("clear while increment pending");
`endif

endmodule
